// ----- src/cvs_pkg.sv -----
// Package for the compacting vector store: request, status and cell command codes,
// fixed port widths and parameter defaults. No dependencies.
package cvs_pkg;

   localparam int DEPTH_DEFAULT      = 256;
   localparam int DATA_WIDTH_DEFAULT = 32;

   localparam int REQ_W    = 3;
   localparam int POS_W    = 8;
   localparam int DIO_W    = 32;
   localparam int STATUS_W = 2;
   localparam int FILL_W   = 9;

   typedef enum logic [REQ_W-1:0] {
      REQ_PUSH         = 3'd0,
      REQ_LOOKUP       = 3'd1,
      REQ_MUTATE       = 3'd2,
      REQ_REMOVE       = 3'd3,
      REQ_REMOVE_VALUE = 3'd4
   } cvs_req_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } cvs_status_type;

   // Command broadcast to every cell of the chain.
   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_WRITE  = 2'd1,
      CELL_SHIFT  = 2'd2,
      CELL_ROTATE = 2'd3
   } cvs_cell_op_type;

   typedef enum logic [1:0] {
      FSM_IDLE  = 2'b01,
      FSM_SWEEP = 2'b10
   } cvs_state_type;

endpackage

// ----- src/cvs_cell.sv -----
// One storage cell of the element chain. It holds one word and loads either the
// broadcast word or the word of its upper neighbor. Depends on cvs_pkg.
module cvs_cell
   import cvs_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT,
   parameter int IDX_WIDTH  = 8,
   parameter int INDEX      = 0
) (
   input  logic                  clock,
   input  cvs_cell_op_type       cell_op,
   input  logic [IDX_WIDTH-1:0]  target_idx,
   input  logic [DATA_WIDTH-1:0] bcast_data,
   input  logic [DATA_WIDTH-1:0] next_data,
   output logic [DATA_WIDTH-1:0] cell_data
);

   localparam logic [IDX_WIDTH-1:0] MyIdx = IDX_WIDTH'(INDEX);

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      case (cell_op)
         CELL_HOLD: begin
            data_in = data_ff;
         end
         CELL_WRITE: begin
            if (MyIdx == target_idx) begin
               data_in = bcast_data;
            end
         end
         CELL_SHIFT: begin
            // Every cell at or above the target takes its neighbor's word.
            if (MyIdx >= target_idx) begin
               data_in = next_data;
            end
         end
         CELL_ROTATE: begin
            if (MyIdx == target_idx) begin
               data_in = bcast_data;
            end else begin
               data_in = next_data;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign cell_data = data_ff;

endmodule

// ----- src/cvs_read_sel.sv -----
// Read selector: picks the word of one cell of the chain by index with an
// AND-OR tree. Depends on cvs_pkg.
module cvs_read_sel
   import cvs_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT,
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int IDX_WIDTH  = 8
) (
   input  logic [DATA_WIDTH-1:0] cells [DEPTH],
   input  logic [IDX_WIDTH-1:0]  sel_idx,
   output logic [DATA_WIDTH-1:0] sel_data
);

   always_comb begin
      sel_data = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (IDX_WIDTH'(i) == sel_idx) begin
            sel_data = sel_data | cells[i];
         end
      end
   end

endmodule

// ----- src/compacting_vector_store_core.sv -----
// Top level of the compacting vector store: control, fill count, result register
// and the chain of cells. Depends on cvs_pkg, cvs_cell and cvs_read_sel.
//
//   Channel   Direction   Ports                                        Handshake
//   request   in          req_type, req_position, req_data_in          req_valid / req_ready
//   response  out         rsp_status, rsp_data_out, rsp_fill_count     rsp_valid / rsp_ready
//
// Push, lookup, mutate, remove and unused codes: the transaction is accepted and its
// response is registered at the same edge. Remove-value first takes one rotation step
// of the cell chain per stored word and then registers its response; on an empty
// store it answers like the other codes.
// Reset clears the fill count, the control state and the response valid; the cell
// contents are not cleared. A stalled response blocks the next request only while
// it is still held; a request is taken in the cycle its predecessor's response leaves.
module compacting_vector_store_core
   import cvs_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,

   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [REQ_W-1:0]           req_type,
   input  logic [POS_W-1:0]           req_position,
   input  logic signed [DIO_W-1:0]    req_data_in,

   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic signed [DIO_W-1:0]    rsp_data_out,
   output logic [FILL_W-1:0]          rsp_fill_count
);

   // Width of the fill count (0 .. DEPTH) and of a cell index (0 .. DEPTH-1).
   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = $clog2(DEPTH);
   // Common width for comparing a request position with the fill count.
   localparam int PW = (CW > POS_W) ? CW : POS_W;

   // Control and result registers.
   cvs_state_type         state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         remain_ff, remain_in;
   logic [DATA_WIDTH-1:0] match_ff, match_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   cvs_status_type        rsp_status_ff, rsp_status_in;
   logic [DATA_WIDTH-1:0] rsp_data_ff, rsp_data_in;
   logic [CW-1:0]         rsp_fill_ff, rsp_fill_in;

   // Cell chain signals.
   logic [DATA_WIDTH-1:0] cell_q [DEPTH];
   cvs_cell_op_type       cell_op;
   logic [IW-1:0]         target_idx;
   logic [DATA_WIDTH-1:0] bcast_data;
   logic [DATA_WIDTH-1:0] read_data;

   logic                  req_fire;
   logic                  is_full;
   logic                  pos_past_end;
   logic [PW-1:0]         pos_wide;
   logic [IW-1:0]         pos_idx;
   logic [DATA_WIDTH-1:0] req_value;
   logic [DATA_WIDTH-1:0] head_data;

   // A new transaction is taken only between sweeps and when the response
   // register is empty or being emptied in this cycle.
   assign req_ready = (state_ff == FSM_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;

   assign pos_wide     = PW'(req_position);
   assign pos_idx      = IW'(pos_wide);
   assign pos_past_end = (pos_wide >= PW'(count_ff));
   assign is_full      = (count_ff == CW'(DEPTH));
   assign req_value    = DATA_WIDTH'($unsigned(req_data_in));
   assign head_data    = cell_q[0];

   // During a sweep the head word is written back at the tail when it is kept.
   assign bcast_data = (state_ff == FSM_SWEEP) ? head_data : req_value;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      remain_in     = remain_ff;
      match_in      = match_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_fill_in   = rsp_fill_ff;
      cell_op       = CELL_HOLD;
      target_idx    = '0;

      case (state_ff)
         FSM_IDLE: begin
            if (req_fire) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_data_in   = '0;
               case (req_type)
                  REQ_PUSH: begin
                     if (is_full) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        cell_op    = CELL_WRITE;
                        target_idx = IW'(count_ff);
                        count_in   = CW'(count_ff + 1'b1);
                     end
                  end
                  REQ_LOOKUP: begin
                     if (pos_past_end) begin
                        rsp_status_in = ST_RANGE;
                     end else begin
                        rsp_data_in = read_data;
                     end
                  end
                  REQ_MUTATE: begin
                     if (pos_past_end) begin
                        rsp_status_in = ST_RANGE;
                     end else begin
                        cell_op    = CELL_WRITE;
                        target_idx = pos_idx;
                     end
                  end
                  REQ_REMOVE: begin
                     if (pos_past_end) begin
                        rsp_status_in = ST_RANGE;
                     end else begin
                        // Later words move down one place to close the gap.
                        rsp_data_in = read_data;
                        cell_op     = CELL_SHIFT;
                        target_idx  = pos_idx;
                        count_in    = CW'(count_ff - 1'b1);
                     end
                  end
                  REQ_REMOVE_VALUE: begin
                     // An empty store answers at once; otherwise the chain is
                     // rotated once through all stored words.
                     if (count_ff != '0) begin
                        rsp_valid_in = 1'b0;
                        state_in     = FSM_SWEEP;
                        remain_in    = count_ff;
                        match_in     = req_value;
                     end
                  end
                  default: begin
                     rsp_status_in = ST_OK;
                  end
               endcase
               rsp_fill_in = count_in;
            end
         end
         FSM_SWEEP: begin
            // The head word leaves the chain each cycle. A word that differs
            // from the match value re-enters at the tail, so the kept words
            // end up in their original order at the bottom of the chain.
            if (head_data != match_ff) begin
               cell_op    = CELL_ROTATE;
               target_idx = IW'(count_ff - 1'b1);
            end else begin
               cell_op    = CELL_SHIFT;
               target_idx = '0;
               count_in   = CW'(count_ff - 1'b1);
            end
            remain_in = CW'(remain_ff - 1'b1);
            if (remain_ff == CW'(1)) begin
               state_in      = FSM_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_data_in   = '0;
               rsp_fill_in   = count_in;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      remain_ff     <= remain_in;
      match_ff      <= match_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_fill_ff   <= rsp_fill_in;
   end

   // The chain of cells; each cell's upper neighbor feeds it on a shift.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] next_word;
      if (i < DEPTH - 1) begin : g_inner
         assign next_word = cell_q[i+1];
      end else begin : g_last
         assign next_word = '0;
      end
      cvs_cell #(
         .DATA_WIDTH (DATA_WIDTH),
         .IDX_WIDTH  (IW),
         .INDEX      (i)
      ) u_cell (
         .clock      (clock),
         .cell_op    (cell_op),
         .target_idx (target_idx),
         .bcast_data (bcast_data),
         .next_data  (next_word),
         .cell_data  (cell_q[i])
      );
   end

   cvs_read_sel #(
      .DATA_WIDTH (DATA_WIDTH),
      .DEPTH      (DEPTH),
      .IDX_WIDTH  (IW)
   ) u_read_sel (
      .cells    (cell_q),
      .sel_idx  (pos_idx),
      .sel_data (read_data)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_data_out   = DIO_W'(rsp_data_ff);
   assign rsp_fill_count = FILL_W'(rsp_fill_ff);

   // The fill count never passes the capacity.
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("fill count above capacity");

   // No response is pending while a sweep is in progress.
   a_sweep_no_rsp : assert property (@(posedge clock) disable iff (reset)
      (state_ff == FSM_SWEEP) |-> (!rsp_valid_ff && remain_ff != '0))
      else $error("response pending or empty sweep during remove-value");

   // A sweep never grows the store.
   a_sweep_shrinks : assert property (@(posedge clock) disable iff (reset)
      (state_ff == FSM_SWEEP) |=> (count_ff <= $past(count_ff)))
      else $error("fill count grew during remove-value");

   // An accepted push into a store with room adds exactly one word.
   a_push_grows : assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_type == REQ_PUSH && !is_full) |=>
         (count_ff == CW'($past(count_ff) + 1'b1)))
      else $error("push did not add one word");

endmodule

// ----- sim/tb_compacting_vector_store_core.sv -----
// Self-checking testbench for compacting_vector_store_core: directed and phased random
// request traffic against a scoreboard that keeps its own copy of the word store.
// Depends on cvs_pkg and the RTL of the core.
module tb;
   import cvs_pkg::*;

   localparam int DEPTH          = DEPTH_DEFAULT;
   localparam int ITEM_TARGET    = 1750;
   localparam int WATCHDOG_LIMIT = 4000;

   // Request codes that the core accepts and ignores.
   localparam logic [REQ_W-1:0] REQ_SPARE_A = 3'd5;
   localparam logic [REQ_W-1:0] REQ_SPARE_B = 3'd6;
   localparam logic [REQ_W-1:0] REQ_SPARE_C = 3'd7;

   localparam logic [DIO_W-1:0] WORD_MAX  = 32'h7FFF_FFFF;
   localparam logic [DIO_W-1:0] WORD_MIN  = 32'h8000_0000;
   localparam logic [DIO_W-1:0] WORD_NEG1 = 32'hFFFF_FFFF;

   // A few recurring values, so that remove-value often hits several words at once.
   localparam logic [DIO_W-1:0] VALUE_POOL [8] = '{
      32'h0000_0000, 32'h0000_0001, WORD_NEG1, WORD_MAX,
      WORD_MIN, 32'h0000_002A, 32'hFFFF_FFD6, 32'h5555_AAAA
   };

   typedef enum {PHASE_FILL, PHASE_DRAIN, PHASE_MIX} phase_kind_type;

   typedef struct {
      cvs_status_type    status;
      logic [DIO_W-1:0]  data;
      logic [FILL_W-1:0] fill;
   } store_result_type;

   // The scoreboard mirrors the ordered store and predicts one response per
   // accepted request transaction; responses are checked in order.
   class store_scoreboard;
      logic [DIO_W-1:0] words [DEPTH];
      int unsigned      count;
      store_result_type awaited [$];
      int unsigned      fails;

      function void note_request(logic [REQ_W-1:0] op, logic [POS_W-1:0] pos,
                                 logic [DIO_W-1:0] value);
         store_result_type r;
         int unsigned      kept;
         r.status = ST_OK;
         r.data   = '0;
         case (op)
            REQ_PUSH: begin
               if (count >= DEPTH) begin
                  r.status = ST_FULL;
               end else begin
                  words[count] = value;
                  count++;
               end
            end
            REQ_LOOKUP: begin
               if (pos >= count) r.status = ST_RANGE;
               else r.data = words[pos];
            end
            REQ_MUTATE: begin
               if (pos >= count) r.status = ST_RANGE;
               else words[pos] = value;
            end
            REQ_REMOVE: begin
               if (pos >= count) begin
                  r.status = ST_RANGE;
               end else begin
                  r.data = words[pos];
                  for (int i = pos; i + 1 < count; i++) words[i] = words[i + 1];
                  count--;
               end
            end
            REQ_REMOVE_VALUE: begin
               kept = 0;
               for (int i = 0; i < count; i++) begin
                  if (words[i] != value) begin
                     words[kept] = words[i];
                     kept++;
                  end
               end
               count = kept;
            end
            default: ;
         endcase
         r.fill = count[FILL_W-1:0];
         awaited.push_back(r);
      endfunction

      function void check_response(logic [STATUS_W-1:0] status, logic [DIO_W-1:0] data,
                                   logic [FILL_W-1:0] fill);
         store_result_type e;
         if (awaited.size() == 0) begin
            $error("response with no request outstanding: status %0d data %h fill %0d",
                   status, data, fill);
            fails++;
            return;
         end
         e = awaited.pop_front();
         if (status !== e.status) begin
            $error("rsp_status: expected %0d, got %0d", e.status, status);
            fails++;
         end
         if (data !== e.data) begin
            $error("rsp_data_out: expected %h, got %h", e.data, data);
            fails++;
         end
         if (fill !== e.fill) begin
            $error("rsp_fill_count: expected %0d, got %0d", e.fill, fill);
            fails++;
         end
      endfunction
   endclass

   logic                    clock          = 1'b0;
   logic                    reset          = 1'b1;
   logic                    req_valid      = 1'b0;
   logic                    req_ready;
   logic [REQ_W-1:0]        req_type       = '0;
   logic [POS_W-1:0]        req_position   = '0;
   logic signed [DIO_W-1:0] req_data_in    = '0;
   logic                    rsp_valid;
   logic                    rsp_ready      = 1'b0;
   logic [STATUS_W-1:0]     rsp_status;
   logic signed [DIO_W-1:0] rsp_data_out;
   logic [FILL_W-1:0]       rsp_fill_count;

   store_scoreboard board;
   int unsigned     sent;
   int unsigned     idle_cycles;
   int unsigned     sink_hold;
   int unsigned     sink_gap;
   bit              src_quiet;
   bit              sink_quiet;

   compacting_vector_store_core u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_position   (req_position),
      .req_data_in    (req_data_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_data_out   (rsp_data_out),
      .rsp_fill_count (rsp_fill_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Idle length for either side of the core. Most gaps are zero or short, a few
   // are long, and a quiet stretch has no gaps at all.
   function automatic int unsigned pick_gap(input bit quiet);
      int unsigned r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 94) return $urandom_range(1, 3);
      return $urandom_range(6, 40);
   endfunction

   // Data for push, mutate and remove-value. Words already in the store are favored
   // for remove-value so that it usually deletes something.
   function automatic logic [DIO_W-1:0] pick_value(input bit match_bias);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 35) return VALUE_POOL[$urandom_range(0, 7)];
      if (board.count > 0 && r < (match_bias ? 85 : 50))
         return board.words[$urandom_range(0, board.count - 1)];
      return $urandom();
   endfunction

   // Mostly a valid index; otherwise any index, which is out of range whenever it
   // lands at or above the fill count.
   function automatic logic [POS_W-1:0] pick_index();
      if (board.count > 0 && $urandom_range(0, 99) < 80)
         return POS_W'($urandom_range(0, board.count - 1));
      return POS_W'($urandom_range(0, 255));
   endfunction

   function automatic logic [REQ_W-1:0] pick_op(input phase_kind_type kind);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 2) return REQ_W'($urandom_range(REQ_SPARE_A, REQ_SPARE_C));
      case (kind)
         PHASE_FILL: begin
            if (r < 90) return REQ_PUSH;
            if (r < 94) return REQ_LOOKUP;
            if (r < 98) return REQ_MUTATE;
            return REQ_REMOVE;
         end
         PHASE_DRAIN: begin
            if (r < 12) return REQ_PUSH;
            if (r < 27) return REQ_LOOKUP;
            if (r < 37) return REQ_MUTATE;
            if (r < 82) return REQ_REMOVE;
            return REQ_REMOVE_VALUE;
         end
         default: begin
            if (r < 35) return REQ_PUSH;
            if (r < 55) return REQ_LOOKUP;
            if (r < 70) return REQ_MUTATE;
            if (r < 88) return REQ_REMOVE;
            return REQ_REMOVE_VALUE;
         end
      endcase
   endfunction

   // Presents one request transaction and returns at the edge that accepts it.
   // Valid is dropped only when a gap precedes the request, so back-to-back
   // transactions keep it high without a second assignment in the same step.
   task automatic send_request(input logic [REQ_W-1:0] op, input logic [POS_W-1:0] pos,
                               input logic [DIO_W-1:0] value);
      int unsigned gap;
      gap = pick_gap(src_quiet);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_type     <= op;
      req_position <= pos;
      req_data_in  <= value;
      do @(posedge clock); while (!req_ready);
      board.note_request(op, pos, value);
      if (op <= REQ_REMOVE_VALUE) sent++;
   endtask

   // Extremes of the data word, every operation, indexes past the end on an empty and
   // a partly filled store, remove-value with and without a match, and spare codes.
   task automatic run_directed();
      send_request(REQ_LOOKUP, 8'd0, WORD_MAX);
      send_request(REQ_MUTATE, 8'd0, WORD_MIN);
      send_request(REQ_REMOVE, 8'd255, WORD_NEG1);
      send_request(REQ_REMOVE_VALUE, 8'd0, '0);
      send_request(REQ_PUSH, 8'd255, WORD_MAX);
      send_request(REQ_PUSH, 8'd0, WORD_MIN);
      send_request(REQ_PUSH, 8'd0, '0);
      send_request(REQ_PUSH, 8'd0, WORD_NEG1);
      send_request(REQ_PUSH, 8'd0, WORD_NEG1);
      send_request(REQ_LOOKUP, 8'd0, '0);
      send_request(REQ_LOOKUP, 8'd4, '0);
      send_request(REQ_LOOKUP, 8'd5, '0);
      send_request(REQ_LOOKUP, 8'd255, '0);
      send_request(REQ_MUTATE, 8'd2, WORD_MIN);
      send_request(REQ_MUTATE, 8'd5, WORD_MAX);
      send_request(REQ_SPARE_A, 8'd255, WORD_NEG1);
      send_request(REQ_SPARE_B, 8'd0, WORD_MIN);
      send_request(REQ_SPARE_C, 8'd1, '0);
      send_request(REQ_REMOVE, 8'd0, '0);
      send_request(REQ_REMOVE_VALUE, 8'd255, WORD_NEG1);
      send_request(REQ_REMOVE_VALUE, 8'd0, 32'h0000_3039);
      send_request(REQ_REMOVE, 8'd1, '0);
      send_request(REQ_LOOKUP, 8'd0, '0);
      send_request(REQ_REMOVE, 8'd0, '0);
      send_request(REQ_REMOVE, 8'd0, '0);
   endtask

   // Random traffic in phases. The first phase pushes well past capacity so that full
   // pushes are exercised; it issues no remove-value. Later phases mix filling, draining
   // and mixed traffic with fresh idle patterns.
   task automatic run_random();
      phase_kind_type   kind;
      int unsigned      phase_len;
      logic [REQ_W-1:0] op;
      logic [POS_W-1:0] pos;
      logic [DIO_W-1:0] value;
      kind      = PHASE_FILL;
      phase_len = 320;
      while (sent < ITEM_TARGET) begin
         src_quiet   = ($urandom_range(0, 3) == 0);
         sink_quiet <= ($urandom_range(0, 3) == 0);
         for (int k = 0; k < phase_len && sent < ITEM_TARGET; k++) begin
            op = pick_op(kind);
            case (op)
               REQ_PUSH, REQ_MUTATE: value = pick_value(1'b0);
               REQ_REMOVE_VALUE: value = pick_value(1'b1);
               default: value = $urandom();
            endcase
            if (op == REQ_LOOKUP || op == REQ_MUTATE || op == REQ_REMOVE) pos = pick_index();
            else pos = POS_W'($urandom_range(0, 255));
            send_request(op, pos, value);
         end
         kind = phase_kind_type'($urandom_range(0, 2));
         case (kind)
            PHASE_FILL: phase_len = $urandom_range(150, 320);
            PHASE_DRAIN: phase_len = $urandom_range(40, 150);
            default: phase_len = $urandom_range(40, 120);
         endcase
      end
   endtask

   // Response side: every accepted response transaction is checked against the
   // oldest prediction, and ready is withheld for random stretches.
   always @(posedge clock) begin
      if (rsp_valid && rsp_ready)
         board.check_response(rsp_status, rsp_data_out, rsp_fill_count);
      if (sink_hold > 0) begin
         sink_hold <= sink_hold - 1;
         rsp_ready <= 1'b0;
      end else begin
         sink_gap   = pick_gap(sink_quiet);
         sink_hold <= sink_gap;
         rsp_ready <= (sink_gap == 0);
      end
   end

   // The longest legal quiet spell is a full-depth remove-value sweep plus the longest
   // stall on either side; the limit is set well above that.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("compacting_vector_store_core: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      board = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      run_random();
      req_valid <= 1'b0;
      // Wait for the last responses, then long enough for a full sweep to show up
      // any stray response.
      while (board.awaited.size() != 0) @(posedge clock);
      repeat (DEPTH + 16) @(posedge clock);
      if (board.fails == 0) $display("compacting_vector_store_core: match");
      else $display("compacting_vector_store_core: mismatch");
      $finish;
   end

endmodule
